### hw/rtl/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg
// Types and constants shared by the windowed rate-of-rise block and its divider
// ----------------------------------------------------------------------------
package wrr_pkg;

  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 12;
  localparam int WIN_W      = 20;
  localparam int TENTHS_W   = 14;
  localparam int RISE_W     = 16;
  localparam int MAG_W      = 30;
  localparam int NUM_W      = 33;
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = 2'd0;
  localparam logic [WIN_W-1:0]      WINDOW_RESET = 20'd30000;

  // quarter degrees per ms to tenths per minute: 60000 * 10 / 4
  localparam logic [17:0] SLOPE_SCALE = 18'd150000;

  localparam logic [RISE_W-1:0] RISE_POS_MAX = 16'h7FFF;
  localparam logic [RISE_W-1:0] RISE_NEG_MAX = 16'h8000;
  localparam logic [NUM_W-1:0]  QUOT_POS_LIM = 33'd32767;
  localparam logic [NUM_W-1:0]  QUOT_NEG_LIM = 33'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SAT,
    ST_FIN
  } wrr_state_t;

endpackage

### hw/rtl/windowed_rate_of_rise.sv
// ----------------------------------------------------------------------------
// windowed_rate_of_rise
// Invalid sample: goes straight to the output stage. Valid sample: the time taken
// grows with n, the ring entries read back (at most RING_DEPTH - 1), through the ring
// walk at one memory read a cycle and the 33-step serial divider. One item at a time.
// No elapsed time skips the divider.
// Synchronous active-low reset clears control state, window_ms to 30000.
// ----------------------------------------------------------------------------
module windowed_rate_of_rise #(
  parameter int RING_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wrr_pkg::TIME_W-1:0]        in_timestamp_ms,
  input  logic [wrr_pkg::TEMP_W-1:0]        in_temp_quarter_deg,
  input  logic                              in_temp_valid,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wrr_pkg::TENTHS_W-1:0]      out_temp_tenths,
  output logic signed [wrr_pkg::RISE_W-1:0] out_rise_tenths_per_min,
  output logic                              out_rise_valid,

  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wrr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [wrr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [wrr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import wrr_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int MW = TEMP_W + TIME_W;

  wrr_state_t state_r, state_nxt;

  logic [WIN_W-1:0]    window_r;
  logic [AW-1:0]       write_slot_r;
  logic [FW-1:0]       fill_r;
  logic [RISE_W-1:0]   last_rise_r;
  logic                last_valid_r;

  logic [TIME_W-1:0]   now_r;
  logic [TEMP_W-1:0]   q_r;
  logic [TENTHS_W-1:0] tenths_r;
  logic [TIME_W-1:0]   old_time_r;
  logic [TEMP_W-1:0]   old_q_r;
  logic [AW-1:0]       idx_r;
  logic [FW-1:0]       cnt_r;
  logic                chk_vld_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [TIME_W-1:0]   dt_r;

  logic                out_valid_r;
  logic [TENTHS_W-1:0] out_tenths_r;
  logic [RISE_W-1:0]   out_rise_r;
  logic                out_rise_valid_r;

  logic [MW-1:0]       ring_mem [RING_DEPTH];
  logic [MW-1:0]       rd_data_r;

  logic                accept;
  logic                mem_we;
  logic                rd_issue;
  logic                div_start;
  logic                out_load;
  logic                cfg_wr;

  logic [TIME_W-1:0]   rd_time;
  logic [TEMP_W-1:0]   rd_q;
  logic [TIME_W-1:0]   age;
  logic                age_ok;
  logic [TIME_W-1:0]   dt;
  logic signed [TEMP_W:0] dq;
  logic [TEMP_W-1:0]   abs_dq;
  logic [TENTHS_W:0]   q_times5;
  logic [AW-1:0]       slot_prev;
  logic [FW-1:0]       walk_cnt;
  logic [NUM_W-1:0]    quot;
  logic                div_done;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_WINDOW);
  assign cfg_prdata = (cfg_paddr == ADDR_WINDOW) ? CFG_DATA_W'(window_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  // datapath helpers
  assign rd_time  = rd_data_r[TIME_W-1:0];
  assign rd_q     = rd_data_r[MW-1:TIME_W];
  assign age      = now_r - rd_time;
  assign age_ok   = age <= TIME_W'(window_r);
  assign dt       = now_r - old_time_r;
  assign dq       = $signed({1'b0, q_r}) - $signed({1'b0, old_q_r});
  assign abs_dq   = dq[TEMP_W] ? TEMP_W'(-dq) : dq[TEMP_W-1:0];
  assign q_times5 = (TENTHS_W+1)'(in_temp_quarter_deg)
                  + (TENTHS_W+1)'({in_temp_quarter_deg, 2'b00});
  assign slot_prev = (write_slot_r == '0) ? AW'(RING_DEPTH - 1) : write_slot_r - 1'b1;
  assign walk_cnt  = (fill_r == FW'(RING_DEPTH)) ? FW'(RING_DEPTH - 1) : fill_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_temp_valid ? ST_WALK : ST_FIN;
        end
      end
      ST_WALK: begin
        if ((chk_vld_r && !age_ok) || (!chk_vld_r && cnt_r == '0)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = (dt == '0) ? ST_FIN : ST_DIV_START;
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    rd_issue  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:      in_stall  = 1'b0;
      ST_WALK:      rd_issue  = !(chk_vld_r && !age_ok) && (cnt_r != '0);
      ST_DIV_START: div_start = 1'b1;
      ST_FIN:       out_load  = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign mem_we = accept && in_temp_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[write_slot_r] <= {in_temp_quarter_deg, in_timestamp_ms};
    end
    if (rd_issue) begin
      rd_data_r <= ring_mem[idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      fill_r       <= '0;
      last_rise_r  <= '0;
      last_valid_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        write_slot_r <= (write_slot_r == AW'(RING_DEPTH - 1)) ? '0 : write_slot_r + 1'b1;
        if (fill_r != FW'(RING_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
        cnt_r     <= walk_cnt;
        chk_vld_r <= 1'b0;
      end else if (state_r == ST_WALK) begin
        chk_vld_r <= rd_issue;
        if (rd_issue) begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      if (state_r == ST_MUL && dt == '0) begin
        last_rise_r  <= '0;
        last_valid_r <= 1'b0;
      end else if (state_r == ST_SAT) begin
        last_valid_r <= 1'b1;
        if (neg_r) begin
          last_rise_r <= (quot > QUOT_NEG_LIM) ? RISE_NEG_MAX : RISE_W'(~quot[RISE_W-1:0] + 1'b1);
        end else begin
          last_rise_r <= (quot > QUOT_POS_LIM) ? RISE_POS_MAX : quot[RISE_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r      <= in_timestamp_ms;
      q_r        <= in_temp_quarter_deg;
      old_time_r <= in_timestamp_ms;
      old_q_r    <= in_temp_quarter_deg;
      idx_r      <= slot_prev;
      tenths_r   <= in_temp_valid ? q_times5[TENTHS_W:1] + TENTHS_W'(q_times5[0]) : '0;
    end else if (state_r == ST_WALK) begin
      if (chk_vld_r && age_ok) begin
        old_time_r <= rd_time;
        old_q_r    <= rd_q;
      end
      if (rd_issue) begin
        idx_r <= (idx_r == '0) ? AW'(RING_DEPTH - 1) : idx_r - 1'b1;
      end
    end
    if (state_r == ST_MUL) begin
      mag_r <= MAG_W'(abs_dq) * MAG_W'(SLOPE_SCALE);
      neg_r <= dq[TEMP_W];
      dt_r  <= dt;
    end
    if (out_load) begin
      out_tenths_r     <= tenths_r;
      out_rise_r       <= last_rise_r;
      out_rise_valid_r <= last_valid_r;
    end
  end

  wrr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mag_r),
    .dt    (dt_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_valid               = out_valid_r;
  assign out_temp_tenths         = out_tenths_r;
  assign out_rise_tenths_per_min = $signed(out_rise_r);
  assign out_rise_valid          = out_rise_valid_r;

endmodule

### hw/rtl/wrr_div.sv
// ----------------------------------------------------------------------------
// wrr_div
// Bit-serial restoring divider for the rounded slope quotient
// (2*mag + dt) / (2*dt), one quotient bit per cycle
// ----------------------------------------------------------------------------
module wrr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wrr_pkg::MAG_W-1:0]   mag,
  input  logic [wrr_pkg::TIME_W-1:0]  dt,
  output logic                        done,
  output logic [wrr_pkg::NUM_W-1:0]   quot
);
  import wrr_pkg::*;

  logic [NUM_W-1:0]     num_r;
  logic [NUM_W-1:0]     den_r;
  logic [NUM_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [NUM_W:0]   rem_sh;
  logic [NUM_W+1:0] diff;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= NUM_W'({mag, 1'b0}) + NUM_W'(dt);
      den_r <= {dt, 1'b0};
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[NUM_W+1]) begin
        rem_r <= diff[NUM_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[NUM_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

### tb/windowed_rate_of_rise_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_rate_of_rise_tb
// Self-checking bench for the trailing-window rate-of-rise block. Temperature
// samples are queued by a stimulus process and sent in bursts by a clocked
// driver; a clocked monitor predicts each reading from its own copy of the
// sample and time history and compares every output transfer field by field.
// The window register is written and read back between drained phases,
// covering its extremes, and the output side stalls on its own random pattern
// including one long hold-off.
// ----------------------------------------------------------------------------
module windowed_rate_of_rise_tb;
  import wrr_pkg::*;

  localparam int          HIST_DEPTH  = 64;
  localparam int          HOLD_CYCLES = 1500;
  localparam int          IDLE_LIMIT  = 10000;
  localparam int          PHASE_ITEMS = 190;
  // quarter degrees per ms to tenths per minute
  localparam longint unsigned SCALE_Q_MS_TO_T_MIN = 150000;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [TEMP_W-1:0] quarter_deg;
    logic              probe_ok;
  } probe_sample_t;

  typedef struct packed {
    logic [TENTHS_W-1:0] tenths;
    logic [RISE_W-1:0]   rise;
    logic                rise_ok;
  } rise_reading_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_kind_t;

  logic                  clk;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_timestamp_ms = '0;
  logic [TEMP_W-1:0]     in_temp_quarter_deg = '0;
  logic                  in_temp_valid = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TENTHS_W-1:0]   out_temp_tenths;
  logic signed [RISE_W-1:0] out_rise_tenths_per_min;
  logic                  out_rise_valid;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = ADDR_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  windowed_rate_of_rise #(
    .RING_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_timestamp_ms         (in_timestamp_ms),
    .in_temp_quarter_deg     (in_temp_quarter_deg),
    .in_temp_valid           (in_temp_valid),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_temp_tenths         (out_temp_tenths),
    .out_rise_tenths_per_min (out_rise_tenths_per_min),
    .out_rise_valid          (out_rise_valid),
    .cfg_psel                (cfg_psel),
    .cfg_penable             (cfg_penable),
    .cfg_pwrite              (cfg_pwrite),
    .cfg_paddr               (cfg_paddr),
    .cfg_pwdata              (cfg_pwdata),
    .cfg_prdata              (cfg_prdata),
    .cfg_pready              (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // bench-side copy of the block state
  logic [TEMP_W-1:0]  temp_hist [HIST_DEPTH];
  logic [TIME_W-1:0]  time_hist [HIST_DEPTH];
  int unsigned        hist_slot = 0;
  int unsigned        hist_fill = 0;
  logic [RISE_W-1:0]  held_rise = '0;
  logic               held_rise_ok = 1'b0;
  logic [WIN_W-1:0]   window_ms = WINDOW_RESET;

  probe_sample_t      pending_samples[$];
  rise_reading_t      expected_readings[$];

  int                 queued_cnt = 0;
  int                 accepted_cnt = 0;
  int                 good_probe_cnt = 0;
  int                 checked_cnt = 0;
  int                 windows_written = 0;
  int                 errors = 0;
  int                 idle_cycles = 0;

  logic               in_took = 1'b0;
  probe_sample_t      next_sample;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 gap_pick;

  bit                 hold_req = 1'b0;
  bit                 hold_taken = 1'b0;
  int                 hold_left = 0;
  stall_kind_t        stall_kind = STALL_NONE;
  int                 stall_kind_left = 0;

  logic [TIME_W-1:0]  walk_ts;
  logic [TEMP_W-1:0]  walk_q;

  function automatic rise_reading_t predict_reading(input logic [TIME_W-1:0] now,
                                                    input logic [TEMP_W-1:0] q,
                                                    input logic ok);
    rise_reading_t    r;
    int unsigned      newest;
    int unsigned      oldest;
    int unsigned      idx;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] dt;
    int               dq;
    longint unsigned  mag;
    longint unsigned  quo;
    int               slope;
    r.tenths = '0;
    if (ok) begin
      r.tenths = TENTHS_W'((5 * int'(q) + 1) / 2);
      newest = hist_slot;
      oldest = newest;
      temp_hist[newest] = q;
      time_hist[newest] = now;
      hist_slot = (newest + 1) % HIST_DEPTH;
      if (hist_fill < HIST_DEPTH) hist_fill++;
      for (int i = 0; i < hist_fill; i++) begin
        idx = (newest + HIST_DEPTH - i) % HIST_DEPTH;
        age = now - time_hist[idx];
        if (age > {{(TIME_W-WIN_W){1'b0}}, window_ms}) break;
        oldest = idx;
      end
      dt = now - time_hist[oldest];
      if (dt == '0) begin
        held_rise = '0;
        held_rise_ok = 1'b0;
      end else begin
        dq = int'(q) - int'(temp_hist[oldest]);
        mag = longint'(dq < 0 ? -dq : dq) * SCALE_Q_MS_TO_T_MIN;
        quo = (2 * mag + dt) / (2 * 64'(dt));
        if (dq < 0) slope = (quo > 32768) ? -32768 : -int'(quo);
        else slope = (quo > 32767) ? 32767 : int'(quo);
        held_rise = RISE_W'(slope);
        held_rise_ok = 1'b1;
      end
    end
    r.rise = held_rise;
    r.rise_ok = held_rise_ok;
    return r;
  endfunction

  // driver: bursts of transfers with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        next_sample = pending_samples.pop_front();
        in_timestamp_ms     <= next_sample.ts;
        in_temp_quarter_deg <= next_sample.quarter_deg;
        in_temp_valid       <= next_sample.probe_ok;
        in_valid            <= 1'b1;
        if (burst_left <= 1) begin
          gap_pick = $urandom_range(0, 9);
          burst_left <= $urandom_range(1, 40);
          gap_left <= (gap_pick < 3) ? 0 :
                      (gap_pick < 8) ? $urandom_range(1, 20) : $urandom_range(21, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (stall_kind_left == 0) begin
        stall_kind <= stall_kind_t'($urandom_range(0, 3));
        stall_kind_left <= $urandom_range(8, 200);
      end else begin
        stall_kind_left <= stall_kind_left - 1;
      end
      case (stall_kind)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= !out_stall;
      endcase
    end
  end

  // monitor: check output transfers, predict on input transfers
  always @(posedge clk) begin
    rise_reading_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("output transfer with no reading expected");
          errors++;
        end else begin
          want = expected_readings.pop_front();
          checked_cnt++;
          if (out_temp_tenths !== want.tenths) begin
            $error("temp_tenths: expected %0d, got %0d", want.tenths, out_temp_tenths);
            errors++;
          end
          if (out_rise_tenths_per_min !== want.rise) begin
            $error("rise_tenths_per_min: expected %0d, got %0d",
                   $signed(want.rise), out_rise_tenths_per_min);
            errors++;
          end
          if (out_rise_valid !== want.rise_ok) begin
            $error("rise_valid: expected %0d, got %0d", want.rise_ok, out_rise_valid);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(in_timestamp_ms, in_temp_quarter_deg,
                                                    in_temp_valid));
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_sample(input logic [TIME_W-1:0] ts, input logic [TEMP_W-1:0] q,
                            input logic ok);
    probe_sample_t s;
    s.ts = ts;
    s.quarter_deg = q;
    s.probe_ok = ok;
    pending_samples.push_back(s);
    queued_cnt++;
    if (ok) good_probe_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic check_window();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_WINDOW;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {{(CFG_DATA_W-WIN_W){1'b0}}, window_ms}) begin
      $error("window_ms: expected %0d, got %0d", window_ms, cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_WINDOW;
    // upper bits are not part of the register
    cfg_pwdata  <= {(CFG_DATA_W-WIN_W)'($urandom), w};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    window_ms = w;
    windows_written++;
    check_window();
  endtask

  task automatic add_random_samples(input int n, input logic [WIN_W-1:0] w);
    int pick;
    int nq;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        walk_ts = $urandom;
        add_sample(walk_ts, TEMP_W'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick >= 5) begin
          if (pick < 10) walk_ts = walk_ts + $urandom;
          else if (pick < 25) walk_ts = walk_ts + $urandom_range(1, 2 * int'(w) + 2);
          else walk_ts = walk_ts + $urandom_range(1, 1000);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          walk_q = '0;
        end else if (pick < 10) begin
          walk_q = '1;
        end else if (pick < 20) begin
          walk_q = TEMP_W'($urandom);
        end else begin
          nq = int'(walk_q) + int'($urandom_range(0, 40)) - 20;
          walk_q = (nq < 0) ? '0 : (nq > 4095) ? '1 : TEMP_W'(nq);
        end
        add_sample(walk_ts, walk_q, $urandom_range(0, 99) >= 10);
      end
    end
  endtask

  initial begin
    logic [WIN_W-1:0] phase_win [8];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_window();

    // reset window: dead probe first, first sample, full-scale jump, slope held
    add_sample(32'h1234_5678, 12'hABC, 1'b0);
    add_sample(32'd0, 12'd0, 1'b1);
    add_sample(32'd1, 12'hFFF, 1'b1);
    add_sample(32'hFFFF_FFFF, 12'hFFF, 1'b0);
    add_sample(32'd300000, 12'd2, 1'b1);
    wait_drained();

    // widest window, timestamp wrap, half rounding up
    write_window(20'hFFFFF);
    add_sample(32'hFFFF_FFF0, 12'd0, 1'b1);
    add_sample(32'h0000_0010, 12'd1, 1'b1);
    add_sample(32'd299984, 12'd1, 1'b1);
    wait_drained();

    // one ms window, negative saturation
    write_window(20'd1);
    add_sample(32'd1000, 12'hFFF, 1'b1);
    add_sample(32'd1001, 12'd0, 1'b1);
    wait_drained();

    // zero window, same timestamp gives no slope, held through a dead probe
    write_window(20'd0);
    add_sample(32'd5000, 12'd100, 1'b1);
    add_sample(32'd5000, 12'd200, 1'b1);
    add_sample(32'd5001, 12'd7, 1'b0);
    wait_drained();

    // upper end of the nominal range, half rounding away from zero
    write_window(20'd600000);
    add_sample(32'd2000000, 12'd1, 1'b1);
    add_sample(32'd2300000, 12'd0, 1'b1);
    add_sample(32'd3000000, 12'd0, 1'b1);
    add_sample(32'd3300000, 12'd1, 1'b1);
    wait_drained();

    phase_win = '{20'd30000, 20'd1, 20'd0, 20'd600000, 20'hFFFFF,
                  WIN_W'($urandom_range(1, 600000)), WIN_W'($urandom_range(2000, 60000)),
                  WIN_W'($urandom)};
    walk_ts = $urandom;
    walk_q = TEMP_W'($urandom);
    for (int p = 0; p < 8; p++) begin
      write_window(phase_win[p]);
      add_random_samples(PHASE_ITEMS, phase_win[p]);
      if (p == 0) hold_req = 1'b1;
      wait_drained();
    end

    repeat (150) @(posedge clk);
    $display("%0d samples sent, %0d with a good probe, %0d readings checked",
             accepted_cnt, good_probe_cnt, checked_cnt);
    $display("%0d window settings incl. 0, 1 and full scale, with a long output hold-off",
             windows_written);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### windowed_rate_of_rise.f
hw/rtl/wrr_pkg.sv
hw/rtl/wrr_div.sv
hw/rtl/windowed_rate_of_rise.sv
tb/windowed_rate_of_rise_tb.sv
